[rtl/core/fla_pkg.sv]
// shared constants and types for the free list block allocator
`timescale 1ns / 1ps

package fla_pkg;

    localparam int IDX_W          = 10;
    localparam int FLD_CNT_W      = 11;
    localparam int STATUS_W       = 2;
    localparam int DEF_MAX_BLOCKS = 1024;
    localparam int RESET_INITIAL  = 1024;
    localparam int GROW_DIV       = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GROWN     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]     granted;
        logic [STATUS_W-1:0]  status;
        logic [FLD_CNT_W-1:0] total;
        logic [FLD_CNT_W-1:0] free;
        logic [FLD_CNT_W-1:0] used;
    } res_t;

endpackage

[rtl/core/free_list_block_allocator.sv]
// top level of the free list block allocator: link memory, counters, result buffer
`timescale 1ns / 1ps

// Pool of fixed-size blocks named by index, handed out from a LIFO free list.
// Input channel (in_valid/in_ready) carries cmd and block_index; cmd alloc
// takes a block, cmd free returns block_index to the head of the list.
// Output channel (out_valid/out_ready) returns one result per transaction:
// granted_index, status and the total, free and used block counts.
// Configuration channel (cfg_valid/cfg_data/cfg_ready) sets the initial pool
// size and restarts the pool; it is taken only while no item is in flight,
// and while cfg_valid is high the input channel is held off.
// A free, an untouched-block alloc, a growth or an exhausted alloc has its
// result registered in the cycle it is accepted (into the hold register if
// the output stalls). An alloc that pops the free list first reads the head's
// link from the single-port synchronous link memory, gives its result in ST_READ
// and holds in_ready low there; all others run at one per cycle unless held off.
// Two result registers sit on the output side, so one more transaction is
// accepted while a result waits; with both full, in_ready drops until the
// receiver takes one.
// Reset empties the free list, clears the counters and sets the initial
// size to 1024 (clamped to MAX_BLOCKS); the link memory needs no clearing
// because an entry is only read after a free has written it.
module free_list_block_allocator #(
    parameter int MAX_BLOCKS = fla_pkg::DEF_MAX_BLOCKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [fla_pkg::IDX_W-1:0]     block_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fla_pkg::IDX_W-1:0]     granted_index,
    output logic [fla_pkg::STATUS_W-1:0]  status,
    output logic [fla_pkg::FLD_CNT_W-1:0] pool_total,
    output logic [fla_pkg::FLD_CNT_W-1:0] pool_free,
    output logic [fla_pkg::FLD_CNT_W-1:0] pool_used,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fla_pkg::FLD_CNT_W-1:0] cfg_data
);

    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W = $clog2(MAX_BLOCKS);
    localparam int CMP_W  = (CNT_W > fla_pkg::FLD_CNT_W) ? CNT_W : fla_pkg::FLD_CNT_W;
    localparam int WORD_W = fla_pkg::IDX_W + 1;
    localparam int RST_INIT_I =
        (fla_pkg::RESET_INITIAL > MAX_BLOCKS) ? MAX_BLOCKS : fla_pkg::RESET_INITIAL;
    localparam logic [CNT_W-1:0] RST_INIT = CNT_W'(RST_INIT_I);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W:0]   MAX_WIDE = (CNT_W + 1)'(MAX_BLOCKS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // link memory: {last entry mark, next index}
    logic [WORD_W-1:0] link_mem [MAX_BLOCKS];
    logic [WORD_W-1:0] rd_word_reg;
    logic              mem_rd_en;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_word;

    logic                      state_reg, state_next;
    logic [CNT_W-1:0]          init_reg, init_next;
    logic [CNT_W-1:0]          total_reg, total_next;
    logic [CNT_W-1:0]          fresh_reg, fresh_next;
    logic [CNT_W-1:0]          used_reg, used_next;
    logic [fla_pkg::IDX_W-1:0] head_reg, head_next;
    logic                      hvalid_reg, hvalid_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      hold_valid_reg, hold_valid_next;
    fla_pkg::res_t             out_reg, out_next;
    fla_pkg::res_t             hold_reg, hold_next;

    logic                      in_fire;
    logic                      cfg_fire;
    logic                      res_fire;
    logic [fla_pkg::IDX_W-1:0] res_granted;
    logic [fla_pkg::STATUS_W-1:0] res_status;
    fla_pkg::res_t             res;

    logic [CMP_W-1:0]          cfg_ext;
    logic [CNT_W-1:0]          cfg_eff;
    logic [CNT_W-1:0]          grow_add;
    logic [CNT_W:0]            grow_sum;
    logic [CNT_W-1:0]          grown_total;
    logic                      bad_free;
    logic [CNT_W-1:0]          free_cnt;

    assign in_ready  = (state_reg == ST_IDLE) && !hold_valid_reg && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // clamp the written size into 1..MAX_BLOCKS
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_data);
        if (cfg_ext == '0)
        begin
            cfg_eff = CNT_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_BLOCKS))
        begin
            cfg_eff = MAX_CNT;
        end
        else
        begin
            cfg_eff = CNT_W'(cfg_ext);
        end
    end

    // growth by half the pool, at least one block, clamped
    always_comb
    begin
        grow_add = CNT_W'(total_reg / fla_pkg::GROW_DIV);
        if (grow_add == '0)
        begin
            grow_add = CNT_W'(1);
        end
        grow_sum = {1'b0, total_reg} + {1'b0, grow_add};
        if (grow_sum > MAX_WIDE)
        begin
            grown_total = MAX_CNT;
        end
        else
        begin
            grown_total = CNT_W'(grow_sum);
        end
    end

    assign bad_free = (CMP_W'(block_index) >= CMP_W'(total_reg)) ||
                      (CMP_W'(block_index) >= CMP_W'(MAX_BLOCKS));

    always_comb
    begin
        state_next  = state_reg;
        init_next   = init_reg;
        total_next  = total_reg;
        fresh_next  = fresh_reg;
        used_next   = used_reg;
        head_next   = head_reg;
        hvalid_next = hvalid_reg;
        res_fire    = 1'b0;
        res_granted = '0;
        res_status  = fla_pkg::ST_OK;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_rd_addr = ADDR_W'(head_reg);
        mem_wr_addr = ADDR_W'(block_index);
        mem_wr_word = {!hvalid_reg, head_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    init_next   = cfg_eff;
                    total_next  = cfg_eff;
                    fresh_next  = '0;
                    used_next   = '0;
                    head_next   = '0;
                    hvalid_next = 1'b0;
                end
                else if (in_fire)
                begin
                    if (cmd == fla_pkg::CMD_ALLOC)
                    begin
                        if (hvalid_reg)
                        begin
                            // head link must come back from memory first
                            mem_rd_en  = 1'b1;
                            state_next = ST_READ;
                        end
                        else if (fresh_reg < total_reg)
                        begin
                            res_fire    = 1'b1;
                            res_granted = fla_pkg::IDX_W'(fresh_reg);
                            fresh_next  = fresh_reg + CNT_W'(1);
                            if (used_reg < total_reg)
                            begin
                                used_next = used_reg + CNT_W'(1);
                            end
                        end
                        else if (total_reg >= MAX_CNT)
                        begin
                            res_fire   = 1'b1;
                            res_status = fla_pkg::ST_EXHAUSTED;
                        end
                        else
                        begin
                            res_fire    = 1'b1;
                            res_status  = fla_pkg::ST_GROWN;
                            res_granted = fla_pkg::IDX_W'(fresh_reg);
                            total_next  = grown_total;
                            fresh_next  = fresh_reg + CNT_W'(1);
                            if (used_reg < grown_total)
                            begin
                                used_next = used_reg + CNT_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        res_fire = 1'b1;
                        if (bad_free)
                        begin
                            res_status = fla_pkg::ST_BAD_FREE;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            head_next   = block_index;
                            hvalid_next = 1'b1;
                            if (used_reg != '0)
                            begin
                                used_next = used_reg - CNT_W'(1);
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                res_fire    = 1'b1;
                res_granted = head_reg;
                if (rd_word_reg[WORD_W-1])
                begin
                    hvalid_next = 1'b0;
                end
                else
                begin
                    head_next = rd_word_reg[fla_pkg::IDX_W-1:0];
                end
                if (used_reg < total_reg)
                begin
                    used_next = used_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign free_cnt    = total_next - used_next;
    assign res.granted = res_granted;
    assign res.status  = res_status;
    assign res.total   = fla_pkg::FLD_CNT_W'(total_next);
    assign res.free    = fla_pkg::FLD_CNT_W'(free_cnt);
    assign res.used    = fla_pkg::FLD_CNT_W'(used_next);

    // two-deep result buffer, hold only fills while the output register stalls
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        hold_next       = hold_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (hold_valid_reg)
            begin
                out_next        = hold_reg;
                out_valid_next  = 1'b1;
                hold_valid_next = res_fire;
                hold_next       = res;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_fire;
            end
        end
        else if (res_fire)
        begin
            hold_next       = res;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            init_reg       <= RST_INIT;
            total_reg      <= RST_INIT;
            fresh_reg      <= '0;
            used_reg       <= '0;
            head_reg       <= '0;
            hvalid_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            total_reg      <= total_next;
            fresh_reg      <= fresh_next;
            used_reg       <= used_next;
            head_reg       <= head_next;
            hvalid_reg     <= hvalid_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            link_mem[mem_wr_addr] <= mem_wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            rd_word_reg <= link_mem[mem_rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_index = out_reg.granted;
    assign status        = out_reg.status;
    assign pool_total    = out_reg.total;
    assign pool_free     = out_reg.free;
    assign pool_used     = out_reg.used;

    a_used_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= total_reg)
        else $error("used count exceeds pool size");

    a_fresh_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= total_reg)
        else $error("untouched pointer beyond pool size");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg >= init_reg) && (total_reg <= MAX_CNT) && (total_reg != '0))
        else $error("pool size out of range");

    a_hold_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("hold register full with output register empty");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_IDLE))
        else $error("link read did not finish in one cycle");

    a_pop_needs_list: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (cmd == fla_pkg::CMD_ALLOC) && hvalid_reg) |=> (state_reg == ST_READ))
        else $error("pop of free list did not start a link read");

endmodule
